// File: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros (clocked on clk, disabled in reset).
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ACMM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ACMM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/acmm_pkg.sv
// ---------------------------------------------------------------------------
// acmm_pkg
// Types, codes and layout helpers for the channel matrix mixer.
// ---------------------------------------------------------------------------
`default_nettype none

package acmm_pkg;

    // Fields carried per item
    localparam int NUM_FIELDS = 8;
    localparam int SAMPLE_W   = 32;
    localparam int SLOTS      = 8;

    // Register indexes
    localparam logic [1:0] REG_IN_CNT  = 2'd0;
    localparam logic [1:0] REG_OUT_CNT = 2'd1;
    localparam logic [1:0] REG_FMT     = 2'd2;

    // Sample format codes
    localparam logic [1:0] FMT_S16 = 2'd0;
    localparam logic [1:0] FMT_S32 = 2'd1;
    localparam logic [1:0] FMT_U8  = 2'd2;

    // Clamp limits
    localparam longint CLAMP_S16_LO = -64'sd32768;
    localparam longint CLAMP_S16_HI = 64'sd32767;
    localparam longint CLAMP_S32_LO = -64'sd2147483648;
    localparam longint CLAMP_S32_HI = 64'sd2147483647;
    localparam longint CLAMP_U8_LO  = 64'sd0;
    localparam longint CLAMP_U8_HI  = 64'sd255;

    // 1/sqrt(2) in Q30
    localparam longint INV_SQRT2_Q30 = 64'd759250125;

    // Kind of coefficient held by one matrix entry
    typedef enum logic [1:0] {
        COEF_ZERO,
        COEF_UNITY,
        COEF_CENTER,
        COEF_SURR
    } coef_code_t;

    // Status from the coefficient controller
    typedef struct packed {
        logic       busy;
        logic [1:0] fmt;
    } ctrl_status_t;

    // Per-stage load enables of the lanes
    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } lane_en_t;

    // Slot mask per channel count: L=0 R=1 C=2 LFE=3 Ls=4 Rs=5 Lb=6 Rb=7
    function automatic logic [7:0] layout_mask(input logic [3:0] cnt);
        logic [7:0] m;
        begin
            unique case (cnt)
                4'd1:    m = 8'h04;
                4'd2:    m = 8'h03;
                4'd3:    m = 8'h07;
                4'd4:    m = 8'h33;
                4'd5:    m = 8'h37;
                4'd6:    m = 8'h3F;
                4'd7:    m = 8'hF7;
                4'd8:    m = 8'hFF;
                default: m = 8'h00;
            endcase
            return m;
        end
    endfunction

    // Slot of the idx-th present channel
    function automatic logic [2:0] slot_of(input logic [7:0] mask, input logic [2:0] idx);
        logic [2:0] found;
        logic [3:0] n;
        begin
            found = 3'd0;
            n     = 4'd0;
            for (int s = 0; s < SLOTS; s++) begin
                if (mask[s]) begin
                    if (n == {1'b0, idx})
                        found = 3'(s);
                    n = n + 4'd1;
                end
            end
            return found;
        end
    endfunction

    // Downmix rule between output slot r and input slot s
    function automatic coef_code_t full_code(input logic [7:0] om, input logic [2:0] r,
                                             input logic [2:0] s);
        coef_code_t c;
        begin
            c = COEF_ZERO;
            if (om == 8'h04) begin
                // mono sum
                if (r == 3'd2) begin
                    if (s == 3'd0 || s == 3'd1)
                        c = COEF_UNITY;
                    else if (s == 3'd2)
                        c = COEF_CENTER;
                    else if (s != 3'd3)
                        c = COEF_SURR;
                end
            end else begin
                if (r == s)
                    c = COEF_UNITY;
                if (!om[2] && s == 3'd2 && (r == 3'd0 || r == 3'd1))
                    c = COEF_CENTER;
                if (!om[4] && ((r == 3'd0 && (s == 3'd4 || s == 3'd6)) ||
                               (r == 3'd1 && (s == 3'd5 || s == 3'd7))))
                    c = COEF_SURR;
                if (!om[6] && ((r == 3'd4 && s == 3'd6) || (r == 3'd5 && s == 3'd7)))
                    c = COEF_SURR;
            end
            return c;
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/acmm_coef_ctrl.sv
// ---------------------------------------------------------------------------
// acmm_coef_ctrl
// Config registers and coefficient matrix rebuild (row sweep, serial divide).
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module acmm_coef_ctrl #(
    parameter int MAX_CHANNELS   = 8,
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [3:0]              cfg_data,
    output acmm_pkg::ctrl_status_t       status,
    output logic [MAX_CHANNELS-1:0][MAX_CHANNELS-1:0][COEF_FRAC_BITS:0] coef
);

    localparam int F      = COEF_FRAC_BITS;
    localparam int CW     = F + 1;
    localparam int GAIN_W = F + 4;
    localparam int ROW_W  = $clog2(MAX_CHANNELS);
    localparam int BIT_W  = $clog2(F);

    localparam logic [CW-1:0] V_ONE = CW'(64'd1 << F);
    localparam logic [CW-1:0] V_C   =
        CW'(((acmm_pkg::INV_SQRT2_Q30 >> (29 - F)) + 64'd1) >> 1);
    localparam logic [CW-1:0] V_S   = CW'(64'd1 << (F - 1));
    localparam logic [GAIN_W-1:0] ONE_G = GAIN_W'(V_ONE);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SUM  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    logic [3:0]        in_cnt_reg, in_cnt_next;
    logic [3:0]        out_cnt_reg, out_cnt_next;
    logic [1:0]        fmt_reg, fmt_next;
    logic [1:0]        state_reg, state_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [GAIN_W-1:0] gmax_reg, gmax_next;
    logic              norm_reg, norm_next;
    logic [1:0]        sel_reg, sel_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [GAIN_W-1:0] rem_reg, rem_next;
    logic [F-1:0]      quo_reg, quo_next;
    logic [CW-1:0]     nval_reg [0:2];
    logic [CW-1:0]     nval_next [0:2];
    logic [MAX_CHANNELS-1:0][MAX_CHANNELS-1:0][CW-1:0] coef_reg;

    logic [3:0]        n_in, n_out;
    logic [7:0]        im, om;
    acmm_pkg::coef_code_t codes [MAX_CHANNELS][MAX_CHANNELS];
    logic [GAIN_W-1:0] row_sum;
    logic [GAIN_W-1:0] max_new;
    logic [GAIN_W:0]   trial;
    logic              fits;
    logic              cnt_write;

    function automatic logic [3:0] eff_count(input logic [3:0] r);
        logic [3:0] e;
        begin
            if (r == 4'd0)
                e = 4'd1;
            else if (r > 4'(MAX_CHANNELS))
                e = 4'(MAX_CHANNELS);
            else
                e = r;
            return e;
        end
    endfunction

    function automatic logic [CW-1:0] raw_value(input acmm_pkg::coef_code_t c);
        logic [CW-1:0] v;
        begin
            unique case (c)
                acmm_pkg::COEF_ZERO:   v = '0;
                acmm_pkg::COEF_UNITY:  v = V_ONE;
                acmm_pkg::COEF_CENTER: v = V_C;
                acmm_pkg::COEF_SURR:   v = V_S;
            endcase
            return v;
        end
    endfunction

    function automatic logic [CW-1:0] sel_raw(input logic [1:0] s);
        logic [CW-1:0] v;
        begin
            unique case (s)
                2'd0:    v = V_ONE;
                2'd1:    v = V_C;
                default: v = V_S;
            endcase
            return v;
        end
    endfunction

    assign n_in  = eff_count(in_cnt_reg);
    assign n_out = eff_count(out_cnt_reg);
    assign im    = acmm_pkg::layout_mask(n_in);
    assign om    = acmm_pkg::layout_mask(n_out);

    // Compacted coefficient codes for the current layouts
    always_comb
    begin
        for (int o = 0; o < MAX_CHANNELS; o++) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                codes[o][i] = acmm_pkg::COEF_ZERO;
                if (4'(o) < n_out && 4'(i) < n_in) begin
                    if (n_in == n_out)
                        codes[o][i] = (o == i) ? acmm_pkg::COEF_UNITY : acmm_pkg::COEF_ZERO;
                    else
                        codes[o][i] = acmm_pkg::full_code(om,
                            acmm_pkg::slot_of(om, 3'(o)), acmm_pkg::slot_of(im, 3'(i)));
                end
            end
        end
    end

    // Sum of the row under the sweep
    always_comb
    begin
        row_sum = '0;
        for (int i = 0; i < MAX_CHANNELS; i++)
            row_sum = row_sum + GAIN_W'(raw_value(codes[row_reg][i]));
    end

    assign max_new   = (row_sum > gmax_reg) ? row_sum : gmax_reg;
    assign trial     = {rem_reg, 1'b0};
    assign fits      = trial >= {1'b0, gmax_reg};
    assign cnt_write = cfg_valid && (cfg_index == acmm_pkg::REG_IN_CNT ||
                                     cfg_index == acmm_pkg::REG_OUT_CNT);

    // Config writes and rebuild sequencer
    always_comb
    begin
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        fmt_next     = fmt_reg;
        state_next   = state_reg;
        row_next     = row_reg;
        gmax_next    = gmax_reg;
        norm_next    = norm_reg;
        sel_next     = sel_reg;
        bit_next     = bit_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        for (int k = 0; k < 3; k++)
            nval_next[k] = nval_reg[k];

        unique case (state_reg)
            S_IDLE:
            begin
            end
            S_SUM:
            begin
                gmax_next = max_new;
                if (row_reg == ROW_W'(MAX_CHANNELS - 1)) begin
                    norm_next  = max_new > ONE_G;
                    state_next = (max_new > ONE_G) ? S_DIV : S_LOAD;
                    sel_next   = 2'd0;
                    bit_next   = '0;
                    rem_next   = GAIN_W'(V_ONE);
                    quo_next   = '0;
                end else begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            S_DIV:
            begin
                rem_next = fits ? GAIN_W'(trial - {1'b0, gmax_reg}) : trial[GAIN_W-1:0];
                quo_next = {quo_reg[F-2:0], fits};
                bit_next = bit_reg + BIT_W'(1);
                if (bit_reg == BIT_W'(F - 1)) begin
                    nval_next[sel_reg] = {1'b0, quo_reg[F-2:0], fits};
                    bit_next = '0;
                    quo_next = '0;
                    if (sel_reg == 2'd2) begin
                        state_next = S_LOAD;
                    end else begin
                        sel_next = sel_reg + 2'd1;
                        rem_next = GAIN_W'(sel_raw(sel_reg + 2'd1));
                    end
                end
            end
            S_LOAD:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid) begin
            unique case (cfg_index)
                acmm_pkg::REG_IN_CNT:  in_cnt_next  = cfg_data;
                acmm_pkg::REG_OUT_CNT: out_cnt_next = cfg_data;
                acmm_pkg::REG_FMT:     fmt_next     = cfg_data[1:0];
                default:
                begin
                end
            endcase
        end

        // A count change restarts the rebuild
        if (cnt_write) begin
            state_next = S_SUM;
            row_next   = '0;
            gmax_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_cnt_reg  <= 4'd2;
            out_cnt_reg <= 4'd2;
            fmt_reg     <= acmm_pkg::FMT_S16;
            state_reg   <= S_SUM;
            row_reg     <= '0;
            gmax_reg    <= '0;
            norm_reg    <= 1'b0;
            sel_reg     <= 2'd0;
            bit_reg     <= '0;
        end else begin
            in_cnt_reg  <= in_cnt_next;
            out_cnt_reg <= out_cnt_next;
            fmt_reg     <= fmt_next;
            state_reg   <= state_next;
            row_reg     <= row_next;
            gmax_reg    <= gmax_next;
            norm_reg    <= norm_next;
            sel_reg     <= sel_next;
            bit_reg     <= bit_next;
        end
    end

    // Divider datapath and normalized values
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        for (int k = 0; k < 3; k++)
            nval_reg[k] <= nval_next[k];
    end

    // Matrix load at the end of a rebuild
    always_ff @(posedge clk)
    begin
        if (state_reg == S_LOAD) begin
            for (int o = 0; o < MAX_CHANNELS; o++) begin
                for (int i = 0; i < MAX_CHANNELS; i++) begin
                    unique case (codes[o][i])
                        acmm_pkg::COEF_ZERO:   coef_reg[o][i] <= '0;
                        acmm_pkg::COEF_UNITY:  coef_reg[o][i] <= norm_reg ? nval_reg[0] : V_ONE;
                        acmm_pkg::COEF_CENTER: coef_reg[o][i] <= norm_reg ? nval_reg[1] : V_C;
                        acmm_pkg::COEF_SURR:   coef_reg[o][i] <= norm_reg ? nval_reg[2] : V_S;
                    endcase
                end
            end
        end
    end

    assign cfg_ready   = 1'b1;
    assign status.busy = state_reg != S_IDLE;
    assign status.fmt  = fmt_reg;
    assign coef        = coef_reg;

    `ACMM_ASSERT_IMP(a_div_only_when_over, state_reg == S_DIV, gmax_reg > ONE_G, "divide without overload")
    `ACMM_ASSERT_NXT(a_count_restarts, cnt_write, state_reg == S_SUM, "count write did not restart rebuild")

endmodule

`default_nettype wire

// File: rtl/core/acmm_lane.sv
// ---------------------------------------------------------------------------
// acmm_lane
// One output channel: parallel products, two partial sums, total.
// ---------------------------------------------------------------------------
`default_nettype none

module acmm_lane #(
    parameter int MAX_CHANNELS   = 8,
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                                  clk,
    input  wire acmm_pkg::lane_en_t                    en,
    input  wire logic [MAX_CHANNELS-1:0][31:0]         samples,
    input  wire logic [MAX_CHANNELS-1:0][COEF_FRAC_BITS:0] coefs,
    output logic signed [COEF_FRAC_BITS+36:0]          total
);

    localparam int PROD_W = COEF_FRAC_BITS + 34;
    localparam int ACC_W  = PROD_W + 3;
    localparam int HALF   = MAX_CHANNELS / 2;

    logic signed [PROD_W-1:0] prod_reg [MAX_CHANNELS];
    logic signed [ACC_W-1:0]  part_reg [2];
    logic signed [ACC_W-1:0]  total_reg;
    logic signed [ACC_W-1:0]  part_lo, part_hi;

    // Products
    always_ff @(posedge clk)
    begin
        if (en.en1) begin
            for (int i = 0; i < MAX_CHANNELS; i++)
                prod_reg[i] <= $signed(samples[i]) * $signed({1'b0, coefs[i]});
        end
    end

    // Partial sums over each half
    always_comb
    begin
        part_lo = '0;
        part_hi = '0;
        for (int i = 0; i < MAX_CHANNELS; i++) begin
            if (i < HALF)
                part_lo = part_lo + ACC_W'(prod_reg[i]);
            else
                part_hi = part_hi + ACC_W'(prod_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.en2) begin
            part_reg[0] <= part_lo;
            part_reg[1] <= part_hi;
        end
        if (en.en3)
            total_reg <= part_reg[0] + part_reg[1];
    end

    assign total = total_reg;

endmodule

`default_nettype wire

// File: rtl/core/acmm_merge.sv
// ---------------------------------------------------------------------------
// acmm_merge
// Scales lane totals, truncates toward zero, clamps and holds the output.
// ---------------------------------------------------------------------------
`default_nettype none

module acmm_merge #(
    parameter int MAX_CHANNELS   = 8,
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic                                    clk,
    input  wire logic                                    en,
    input  wire logic [1:0]                              fmt,
    input  wire logic [MAX_CHANNELS-1:0][COEF_FRAC_BITS+36:0] totals,
    input  wire logic                                    last_in,
    output logic [255:0]                                 data,
    output logic                                         last
);

    localparam int F     = COEF_FRAC_BITS;
    localparam int ACC_W = F + 37;
    localparam int QW    = ACC_W - F;

    logic [31:0]             out_reg [MAX_CHANNELS];
    logic                    last_reg;
    logic signed [QW-1:0]    lo, hi;
    logic signed [ACC_W-1:0] biased [MAX_CHANNELS];
    logic signed [QW-1:0]    q [MAX_CHANNELS];
    logic [31:0]             clamped [MAX_CHANNELS];

    // Clamp range
    always_comb
    begin
        unique case (fmt)
            acmm_pkg::FMT_S32:
            begin
                lo = QW'(acmm_pkg::CLAMP_S32_LO);
                hi = QW'(acmm_pkg::CLAMP_S32_HI);
            end
            acmm_pkg::FMT_U8:
            begin
                lo = QW'(acmm_pkg::CLAMP_U8_LO);
                hi = QW'(acmm_pkg::CLAMP_U8_HI);
            end
            default:
            begin
                lo = QW'(acmm_pkg::CLAMP_S16_LO);
                hi = QW'(acmm_pkg::CLAMP_S16_HI);
            end
        endcase
    end

    // Truncate toward zero, then clamp
    always_comb
    begin
        for (int o = 0; o < MAX_CHANNELS; o++) begin
            biased[o] = $signed(totals[o]) +
                        (totals[o][ACC_W-1] ? ACC_W'((64'd1 << F) - 64'd1) : ACC_W'(0));
            q[o] = biased[o][ACC_W-1:F];
            if (q[o] < lo)
                clamped[o] = lo[31:0];
            else if (q[o] > hi)
                clamped[o] = hi[31:0];
            else
                clamped[o] = q[o][31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            for (int o = 0; o < MAX_CHANNELS; o++)
                out_reg[o] <= clamped[o];
            last_reg <= last_in;
        end
    end

    // Pack, channels past the lane count read zero
    always_comb
    begin
        data = '0;
        for (int o = 0; o < MAX_CHANNELS; o++)
            data[32*o +: 32] = out_reg[o];
    end

    assign last = last_reg;

endmodule

`default_nettype wire

// File: rtl/core/audio_channel_matrix_mixer.sv
// ---------------------------------------------------------------------------
// audio_channel_matrix_mixer
// Multichannel downmix/upmix matrix with per-format output clamp.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one frame per item: eight 32-bit samples in tdata, the
//   buffer end flag in tlast. m_axis returns the mixed frame the same way.
//   cfg writes the input/output channel counts and the sample format.
//   Throughput is one item per clock while the receiver is ready and no rebuild
//   runs. Stages: product, partial sums, total, scale/clamp register to m_axis_tvalid.
//   Every output channel has its own lane of MAX_CHANNELS multipliers.
//   After reset and after each channel count write the coefficient matrix is
//   rebuilt, with s_axis_tready low: a row sweep, then a serial divide of the
//   three normalized values when a row gain exceeds 1.0.
//   A stalled receiver holds the output register; items in flight close up
//   behind it and intake stops only once every stage is full.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module audio_channel_matrix_mixer #(
    parameter int MAX_CHANNELS   = 8,
    parameter int COEF_FRAC_BITS = 16
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [255:0] s_axis_tdata,   // sample_0 .. sample_7, 32 bits each
    input  wire logic         s_axis_tlast,   // last_frame
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [255:0]      m_axis_tdata,   // mixed_0 .. mixed_7, 32 bits each
    output logic              m_axis_tlast,   // frame_end
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [1:0]   cfg_index,
    input  wire logic [3:0]   cfg_data
);

    localparam int TOT_W = COEF_FRAC_BITS + 37;

    acmm_pkg::ctrl_status_t status;
    acmm_pkg::lane_en_t     lane_en;
    logic [MAX_CHANNELS-1:0][MAX_CHANNELS-1:0][COEF_FRAC_BITS:0] coef;
    logic [MAX_CHANNELS-1:0][31:0]      samples;
    logic [MAX_CHANNELS-1:0][TOT_W-1:0] totals;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic l1_reg, l2_reg, l3_reg;
    logic en1, en2, en3, en4;
    logic in_fire;

    acmm_coef_ctrl #(
        .MAX_CHANNELS   (MAX_CHANNELS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .coef      (coef)
    );

    // Stage enables: a stage loads when empty or when the next one loads
    assign en4     = !v4_reg || m_axis_tready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_axis_tready = en1 && !status.busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    assign lane_en.en1 = en1;
    assign lane_en.en2 = en2;
    assign lane_en.en3 = en3;

    always_comb
    begin
        for (int i = 0; i < MAX_CHANNELS; i++)
            samples[i] = s_axis_tdata[32*i +: 32];
    end

    // One lane per output channel
    for (genvar o = 0; o < MAX_CHANNELS; o++) begin : g_lane
        acmm_lane #(
            .MAX_CHANNELS   (MAX_CHANNELS),
            .COEF_FRAC_BITS (COEF_FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .en      (lane_en),
            .samples (samples),
            .coefs   (coef[o]),
            .total   (totals[o])
        );
    end

    acmm_merge #(
        .MAX_CHANNELS   (MAX_CHANNELS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_merge (
        .clk     (clk),
        .en      (en4),
        .fmt     (status.fmt),
        .totals  (totals),
        .last_in (l3_reg),
        .data    (m_axis_tdata),
        .last    (m_axis_tlast)
    );

    // Valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1)
                v1_reg <= in_fire;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    // Frame end flag alongside the lanes
    always_ff @(posedge clk)
    begin
        if (en1)
            l1_reg <= s_axis_tlast;
        if (en2)
            l2_reg <= l1_reg;
        if (en3)
            l3_reg <= l2_reg;
    end

    assign m_axis_tvalid = v4_reg;

    `ACMM_ASSERT_IMP(a_no_intake_in_rebuild, status.busy, !s_axis_tready, "intake during rebuild")
    `ACMM_ASSERT_NXT(a_item_enters_lanes, in_fire, v1_reg, "accepted item missing from first stage")

endmodule

`default_nettype wire

// File: verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the channel matrix mixer: a queue-fed driver pushes
// audio frames, a predictor derives the downmix matrix for each channel-count
// setting and computes the expected mixed frame, and a monitor compares every
// output item against the oldest prediction.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int NCH       = 8;
    localparam int FRAC      = 16;
    localparam int RAND_ITEMS = 1600;

    typedef struct {
        logic [31:0] smp [NCH];
        logic        last;
    } frame_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [255:0] s_axis_tdata;    // sample_0 .. sample_7
    logic         s_axis_tlast;    // last_frame
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [255:0] m_axis_tdata;    // mixed_0 .. mixed_7
    logic         m_axis_tlast;    // frame_end
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [3:0]   cfg_data;

    // predictor state
    logic [3:0]   in_cnt_reg;
    logic [3:0]   out_cnt_reg;
    logic [1:0]   fmt_reg;
    longint       coef [NCH][NCH];

    frame_t       pending_frames [$];
    frame_t       expected_mix [$];
    int           send_idle_pct;
    int           recv_idle_pct;
    int           hold_recv;
    int           mismatches;
    bit           unexpected_seen;

    audio_channel_matrix_mixer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int eff_count(input logic [3:0] r);
        if (r == 4'd0)
            return 1;
        if (r > NCH)
            return NCH;
        return int'(r);
    endfunction

    function automatic logic [7:0] mask_for(input int n);
        logic [7:0] m;
        case (n)
            1:       m = 8'h04;
            2:       m = 8'h03;
            3:       m = 8'h07;
            4:       m = 8'h33;
            5:       m = 8'h37;
            6:       m = 8'h3F;
            7:       m = 8'hF7;
            default: m = 8'hFF;
        endcase
        return m;
    endfunction

    // Derive the downmix matrix from the current channel counts
    task automatic build_coefs();
        longint full [NCH][NCH];
        int     rows [NCH];
        int     cols [NCH];
        int     n_in;
        int     n_out;
        int     k;
        logic [7:0] im;
        logic [7:0] om;
        longint one;
        longint c_ctr;
        longint c_sur;
        longint gain;
        longint peak_gain;
        n_in  = eff_count(in_cnt_reg);
        n_out = eff_count(out_cnt_reg);
        im    = mask_for(n_in);
        om    = mask_for(n_out);
        one   = longint'(1) << FRAC;
        c_ctr = (((longint'(acmm_pkg::INV_SQRT2_Q30)) >> (29 - FRAC)) + 1) >> 1;
        c_sur = longint'(1) << (FRAC - 1);
        peak_gain = 0;
        for (int o = 0; o < NCH; o++)
            for (int i = 0; i < NCH; i++)
            begin
                coef[o][i] = 0;
                full[o][i] = 0;
            end
        if (n_in == n_out)
        begin
            for (int o = 0; o < n_out; o++)
                coef[o][o] = one;
            return;
        end
        if (om == 8'h04)
        begin
            full[2][0] = one;   full[2][1] = one;   full[2][2] = c_ctr;
            full[2][4] = c_sur; full[2][5] = c_sur;
            full[2][6] = c_sur; full[2][7] = c_sur;
        end
        else
        begin
            for (int o = 0; o < NCH; o++)
                full[o][o] = one;
            if (!om[2])
            begin
                full[0][2] = c_ctr;
                full[1][2] = c_ctr;
            end
            if (!om[4])
            begin
                full[0][4] = c_sur; full[1][5] = c_sur;
                full[0][6] = c_sur; full[1][7] = c_sur;
            end
            if (!om[6])
            begin
                full[4][6] = c_sur;
                full[5][7] = c_sur;
            end
        end
        k = 0;
        for (int s = 0; s < NCH; s++)
            if (im[s])
            begin
                cols[k] = s;
                k++;
            end
        k = 0;
        for (int s = 0; s < NCH; s++)
            if (om[s])
            begin
                rows[k] = s;
                k++;
            end
        for (int o = 0; o < n_out; o++)
        begin
            gain = 0;
            for (int i = 0; i < n_in; i++)
            begin
                coef[o][i] = full[rows[o]][cols[i]];
                gain += coef[o][i];
            end
            if (gain > peak_gain)
                peak_gain = gain;
        end
        if (peak_gain > one)
            for (int o = 0; o < n_out; o++)
                for (int i = 0; i < n_in; i++)
                    coef[o][i] = (coef[o][i] * one) / peak_gain;
    endtask

    // Expected mixed frame for one input frame
    function automatic frame_t mix_frame(input frame_t f);
        frame_t r;
        longint acc;
        longint q;
        longint lo;
        longint hi;
        int     n_in;
        int     n_out;
        n_in  = eff_count(in_cnt_reg);
        n_out = eff_count(out_cnt_reg);
        case (fmt_reg)
            acmm_pkg::FMT_S32:
            begin
                lo = acmm_pkg::CLAMP_S32_LO;
                hi = acmm_pkg::CLAMP_S32_HI;
            end
            acmm_pkg::FMT_U8:
            begin
                lo = acmm_pkg::CLAMP_U8_LO;
                hi = acmm_pkg::CLAMP_U8_HI;
            end
            default:
            begin
                lo = acmm_pkg::CLAMP_S16_LO;
                hi = acmm_pkg::CLAMP_S16_HI;
            end
        endcase
        for (int o = 0; o < NCH; o++)
        begin
            r.smp[o] = 32'd0;
            if (o < n_out)
            begin
                acc = 0;
                for (int i = 0; i < n_in; i++)
                    acc += longint'(signed'(f.smp[i])) * coef[o][i];
                q = acc / (longint'(1) << FRAC);
                if (q < lo)
                    q = lo;
                if (q > hi)
                    q = hi;
                r.smp[o] = q[31:0];
            end
        end
        r.last = f.last;
        return r;
    endfunction

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000 + $urandom_range(0, 3);
            1:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2:       return 32'($signed($urandom_range(0, 65535)) - 32768);
            3:       return 32'($urandom_range(0, 255));
            4:       return 32'($signed($urandom_range(0, 131071)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    // Driver: one frame per handshake from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_frames.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                frame_t f;
                f = pending_frames.pop_front();
                for (int i = 0; i < NCH; i++)
                    s_axis_tdata[32*i +: 32] <= f.smp[i];
                s_axis_tlast  <= f.last;
                s_axis_tvalid <= 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Predict on acceptance
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            frame_t f;
            for (int i = 0; i < NCH; i++)
                f.smp[i] = s_axis_tdata[32*i +: 32];
            f.last = s_axis_tlast;
            expected_mix.push_back(mix_frame(f));
        end
    end

    // Receiver backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_recv > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_recv <= hold_recv - 1;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Monitor: compare each output item with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            frame_t e;
            bit     bad;
            if (expected_mix.size() == 0)
            begin
                unexpected_seen = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("output item with nothing expected: %h", m_axis_tdata);
            end
            else
            begin
                e = expected_mix.pop_front();
                bad = (m_axis_tlast !== e.last);
                for (int o = 0; o < NCH; o++)
                    if (m_axis_tdata[32*o +: 32] !== e.smp[o])
                        bad = 1'b1;
                if (bad)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at %0t: last exp %b got %b", $time, e.last,
                                 m_axis_tlast);
                        for (int o = 0; o < NCH; o++)
                            $display("  mixed_%0d exp %h got %h", o, e.smp[o],
                                     m_axis_tdata[32*o +: 32]);
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] val);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == acmm_pkg::REG_IN_CNT)
        begin
            in_cnt_reg = val;
            build_coefs();
        end
        else if (idx == acmm_pkg::REG_OUT_CNT)
        begin
            out_cnt_reg = val;
            build_coefs();
        end
        else if (idx == acmm_pkg::REG_FMT)
            fmt_reg = val[1:0];
    endtask

    // Let the pipe drain before touching registers
    task automatic drain();
        while (pending_frames.size() > 0 || s_axis_tvalid || expected_mix.size() > 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic queue_random(input int n);
        frame_t f;
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < NCH; i++)
                f.smp[i] = rand_sample();
            f.last = 1'($urandom_range(0, 1));
            pending_frames.push_back(f);
        end
    endtask

    task automatic queue_fill(input logic [31:0] v, input logic last);
        frame_t f;
        for (int i = 0; i < NCH; i++)
            f.smp[i] = v;
        f.last = last;
        pending_frames.push_back(f);
    endtask

    // Stimulus
    initial
    begin
        int phase_items;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = acmm_pkg::REG_IN_CNT;
        cfg_data      = 4'd0;
        send_idle_pct = 7;
        recv_idle_pct = 64;
        hold_recv     = 0;
        mismatches    = 0;
        unexpected_seen = 1'b0;
        in_cnt_reg    = 4'd2;
        out_cnt_reg   = 4'd2;
        fmt_reg       = acmm_pkg::FMT_S16;
        build_coefs();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes at reset setting
        queue_fill(32'h7FFF_FFFF, 1'b1);
        queue_fill(32'h8000_0000, 1'b0);
        queue_fill(32'h0000_0000, 1'b1);
        queue_fill(32'hFFFF_FFFF, 1'b0);
        queue_fill(32'h0000_7FFF, 1'b1);
        queue_fill(32'hFFFF_8000, 1'b0);
        drain();

        // Directed: 7.1 to mono, 7.1 to stereo, then out-of-range counts giving mono to 7.1 and mono to mono
        write_reg(acmm_pkg::REG_IN_CNT, 4'd8);
        write_reg(acmm_pkg::REG_OUT_CNT, 4'd1);
        write_reg(acmm_pkg::REG_FMT, 4'(acmm_pkg::FMT_S32));
        queue_fill(32'h7FFF_FFFF, 1'b0);
        queue_fill(32'h8000_0000, 1'b1);
        queue_fill(32'h0001_0000, 1'b0);
        drain();
        write_reg(acmm_pkg::REG_OUT_CNT, 4'd2);
        write_reg(acmm_pkg::REG_FMT, 4'(acmm_pkg::FMT_U8));
        queue_fill(32'h0000_00FF, 1'b1);
        queue_fill(32'hFFFF_FF00, 1'b0);
        queue_fill(32'h0000_1000, 1'b1);
        drain();
        write_reg(acmm_pkg::REG_IN_CNT, 4'd0);
        write_reg(acmm_pkg::REG_OUT_CNT, 4'd15);
        write_reg(acmm_pkg::REG_FMT, 4'd3);
        queue_fill(32'h7FFF_FFFF, 1'b0);
        queue_fill(32'h0000_1234, 1'b1);
        drain();
        write_reg(acmm_pkg::REG_OUT_CNT, 4'd0);
        queue_fill(32'h8000_0000, 1'b0);
        queue_fill(32'h0000_4321, 1'b1);
        drain();

        // Random phases through many settings
        for (int ph = 0; ph < 16; ph++)
        begin
            if (ph == 5)
            begin
                send_idle_pct = 64;
                recv_idle_pct = 7;
            end
            else if (ph == 10)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_reg(acmm_pkg::REG_IN_CNT, 4'($urandom_range(0, 9)));
            write_reg(acmm_pkg::REG_OUT_CNT, 4'($urandom_range(0, 9)));
            write_reg(acmm_pkg::REG_FMT, 4'($urandom_range(0, 3)));
            phase_items = RAND_ITEMS / 16;
            if (ph == 11)
            begin
                // long receiver stall while the sender keeps offering
                hold_recv = 200;
                queue_random(phase_items);
            end
            else if (ph == 12)
            begin
                queue_random(phase_items / 2);
                while (pending_frames.size() > 0 || s_axis_tvalid || expected_mix.size() > 0)
                    @(posedge clk);
                queue_random(phase_items / 2);
            end
            else
                queue_random(phase_items);
            drain();
        end

        if (mismatches == 0 && !unexpected_seen && expected_mix.size() == 0)
            $display("PASS audio_channel_matrix_mixer");
        else
            $display("FAIL audio_channel_matrix_mixer");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("FAIL audio_channel_matrix_mixer");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl/core
rtl/core/acmm_pkg.sv
rtl/core/acmm_coef_ctrl.sv
rtl/core/acmm_lane.sv
rtl/core/acmm_merge.sv
rtl/core/audio_channel_matrix_mixer.sv
verif/tb.sv
